/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/arpht_pkg.sv */
`timescale 1ns / 1ps
package arpht_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 256;
  localparam int HOST_COUNT_W          = 9;

  localparam logic [2:0] OP_LEARN_ARP  = 3'd0;
  localparam logic [2:0] OP_LEARN_RARP = 3'd1;
  localparam logic [2:0] OP_ADD_OWN    = 3'd2;
  localparam logic [2:0] OP_LOOKUP_IP  = 3'd3;
  localparam logic [2:0] OP_LOOKUP_MAC = 3'd4;

  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [7:0]  OPC_ARP_REPLY  = 8'h02;
  localparam logic [7:0]  OPC_RARP_REPLY = 8'h04;
  localparam int          SCAN_FIRST     = 1;
  localparam int          SCAN_END       = 255;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] ethertype;
    logic [7:0]  arp_opcode;
    logic [47:0] frame_mac;
    logic [31:0] frame_ip;
    logic [31:0] want_ip;
    logic [47:0] want_mac;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic [47:0]             out_mac;
    logic [31:0]             out_ip;
    logic [HOST_COUNT_W-1:0] host_count;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

/* rtl/core/arp_host_table.sv */
`timescale 1ns / 1ps
// channel  | handshake             | payload
// in_      | in_valid / in_ready   | in_data  (arpht_pkg::in_t)
// out_     | out_valid / out_ready | out_data (arpht_pkg::out_t)
//
// Learn/add and unused ops: accept (IDLE), execute (EXEC), then load the result register (FINISH).
// Lookup by IP: adds a WAIT state between EXEC and FINISH (one registered read of the host memory).
// Lookup by MAC: scans up to min(254, TABLE_ENTRIES-1) entries, one entry per cycle
// through the single memory read port and one 48-bit comparator.
// Reset clears valid marks and host count at once; no clearing pass.
// One transaction at a time; a held result stalls only the next finishing op.
`include "assert_macros.svh"
module arp_host_table #(
  parameter int TABLE_ENTRIES = arpht_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  arpht_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output arpht_pkg::out_t  out_data
);
  import arpht_pkg::*;

  localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCAN_LAST = (TABLE_ENTRIES - 1 < SCAN_END - 1) ?
                             (TABLE_ENTRIES - 1) : (SCAN_END - 1);

  state_t                  state_r, state_nxt;
  in_t                     req_r;
  logic                    hit_r, hit_nxt;
  logic [47:0]             mac_r, mac_nxt;
  logic [31:0]             ip_r, ip_nxt;
  logic [IDX_W-1:0]        ptr_r, ptr_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r;
  out_t                    out_data_r;
  logic                    load_out;

  store_ctrl_t             ctrl;
  logic [IDX_W-1:0]        mem_addr;
  entry_t                  wr_entry;
  entry_t                  rd_entry;
  logic                    rd_valid;
  logic [HOST_COUNT_W-1:0] host_count;

  logic                    arp_ok;
  logic                    rarp_ok;
  logic [7:0]              slot;
  logic                    slot_in_range;
  logic                    mac_match;

  arpht_store #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .addr      (mem_addr),
    .wr_entry  (wr_entry),
    .rd_entry  (rd_entry),
    .rd_valid  (rd_valid),
    .host_count(host_count)
  );

  assign arp_ok  = (req_r.ethertype == ETHERTYPE_ARP) && (req_r.arp_opcode == OPC_ARP_REPLY) &&
                   (req_r.frame_ip == req_r.want_ip);
  assign rarp_ok = (req_r.ethertype == ETHERTYPE_ARP) && (req_r.arp_opcode == OPC_RARP_REPLY) &&
                   (req_r.frame_mac == req_r.want_mac);
  assign mac_match = rd_valid && (rd_entry.mac == req_r.want_mac);

  always_comb begin
    slot     = req_r.frame_ip[7:0];
    wr_entry = '{ip: req_r.frame_ip, mac: req_r.frame_mac};
    case (req_r.op)
      OP_LEARN_ARP: begin
        slot     = req_r.want_ip[7:0];
        wr_entry = '{ip: req_r.want_ip, mac: req_r.frame_mac};
      end
      OP_LEARN_RARP: begin
        wr_entry = '{ip: req_r.frame_ip, mac: req_r.want_mac};
      end
      OP_LOOKUP_IP: begin
        slot = req_r.want_ip[7:0];
      end
      default: begin
      end
    endcase
  end

  assign slot_in_range = ({1'b0, slot} < 9'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (req_r.op)
          OP_LOOKUP_IP:  state_nxt = S_WAIT;
          OP_LOOKUP_MAC: state_nxt = S_SCAN;
          default:       state_nxt = S_FINISH;
        endcase
      end
      S_WAIT: state_nxt = S_FINISH;
      S_SCAN: begin
        if (mac_match || last_r) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    ctrl     = '0;
    mem_addr = slot[IDX_W-1:0];
    hit_nxt  = hit_r;
    mac_nxt  = mac_r;
    ip_nxt   = ip_r;
    ptr_nxt  = ptr_r;
    last_nxt = last_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXEC: begin
        hit_nxt = 1'b0;
        mac_nxt = '0;
        ip_nxt  = '0;
        case (req_r.op)
          OP_LEARN_ARP: begin
            ctrl.we = arp_ok && slot_in_range;
            hit_nxt = arp_ok && slot_in_range;
          end
          OP_LEARN_RARP: begin
            ctrl.we = rarp_ok && slot_in_range;
            hit_nxt = rarp_ok && slot_in_range;
          end
          OP_ADD_OWN: begin
            ctrl.we = slot_in_range;
            hit_nxt = slot_in_range;
          end
          OP_LOOKUP_IP: begin
            ctrl.re = slot_in_range;
          end
          OP_LOOKUP_MAC: begin
            ctrl.re  = 1'b1;
            mem_addr = IDX_W'(SCAN_FIRST);
            last_nxt = (SCAN_FIRST == SCAN_LAST);
            ptr_nxt  = IDX_W'(SCAN_FIRST + 1);
          end
          default: begin
          end
        endcase
      end
      S_WAIT: begin
        hit_nxt = slot_in_range && rd_valid;
        mac_nxt = (slot_in_range && rd_valid) ? rd_entry.mac : '0;
      end
      S_SCAN: begin
        if (mac_match) begin
          hit_nxt = 1'b1;
          ip_nxt  = rd_entry.ip;
        end else if (!last_r) begin
          ctrl.re  = 1'b1;
          mem_addr = ptr_r;
          last_nxt = (ptr_r == IDX_W'(SCAN_LAST));
          ptr_nxt  = IDX_W'(ptr_r + 1'b1);
        end
      end
      S_FINISH: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    hit_r  <= hit_nxt;
    mac_r  <= mac_nxt;
    ip_r   <= ip_nxt;
    ptr_r  <= ptr_nxt;
    last_r <= last_nxt;
    if (load_out) begin
      out_data_r <= '{hit: hit_r, out_mac: mac_r, out_ip: ip_r, host_count: host_count};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, host_count <= 9'(TABLE_ENTRIES))
  `ASSERT_IMPL(a_count_step, clk, rst_n, $past(rst_n), (host_count == $past(host_count)) || (host_count == 9'($past(host_count) + 9'd1)))
  `ASSERT_IMPL(a_store_idle_out, clk, rst_n, ctrl.we, state_r == S_EXEC)

endmodule

/* rtl/core/arpht_store.sv */
`timescale 1ns / 1ps
module arpht_store #(
  parameter int TABLE_ENTRIES = arpht_pkg::DEFAULT_TABLE_ENTRIES,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  arpht_pkg::store_ctrl_t                ctrl,
  input  logic [IDX_W-1:0]                      addr,
  input  arpht_pkg::entry_t                     wr_entry,
  output arpht_pkg::entry_t                     rd_entry,
  output logic                                  rd_valid,
  output logic [arpht_pkg::HOST_COUNT_W-1:0]    host_count
);
  import arpht_pkg::*;

  entry_t                  mem [TABLE_ENTRIES];
  entry_t                  rd_entry_r;
  logic                    rd_valid_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [HOST_COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[addr] <= wr_entry;
    end
    if (ctrl.re) begin
      rd_entry_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctrl.we) begin
        valid_r[addr] <= 1'b1;
        if (!valid_r[addr]) begin
          count_r <= HOST_COUNT_W'(count_r + 1'b1);
        end
      end
      if (ctrl.re) begin
        rd_valid_r <= valid_r[addr];
      end
    end
  end

  assign rd_entry   = rd_entry_r;
  assign rd_valid   = rd_valid_r;
  assign host_count = count_r;

endmodule
